// ===== hw/rtl/vde_pkg.sv =====
// Shared types and constants of the vector distance engine.
// No dependencies; every other file of the block imports this package.
package vde_pkg;

	localparam int ELEM_WIDTH_DEF = 16;
	localparam int DIST_W         = 48;
	localparam int NORM_W         = 42;
	localparam int MODE_W         = 2;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;
	localparam int ROOT_W         = DIST_W / 2;
	localparam int JQ_DEPTH_DEF   = 4;
	localparam int LIMIT_W        = 24;

	// Metric selector codes; the unused code behaves as Manhattan.
	localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EUCLID    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NORM      = 2'd2;

	// Register index of the metric selector.
	localparam logic [PADDR_W-3:0] REG_METRIC_MODE = 1'b0;

	localparam logic signed [DIST_W-1:0] SUM_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] SUM_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	// A difference above this magnitude squares to more than the sum can hold.
	localparam logic [LIMIT_W-1:0] DIFF_SQ_LIMIT = {LIMIT_W{1'b1}};

	// Highest even bit position for the digit-by-digit root.
	localparam logic [DIST_W-1:0] ROOT_TOP_BIT = {2'b01, {(DIST_W-2){1'b0}}};

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DIST_W-1:0] sum;
		logic [NORM_W-1:0]        norm_a;
		logic [NORM_W-1:0]        norm_b;
	} vde_job_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_ROOT
	} vde_back_st_t;

endpackage

// ===== hw/rtl/vector_distance_engine_top.sv =====
// Top level of the vector distance engine: register port, front end, job queue, back end.
// Depends on vde_pkg, vde_front, vde_jobq and vde_back.
//
//   Channel   Handshake                          Payload
//   input     push / full                        elem_a, elem_b, norm_a, norm_b, last_element
//   result    empty / pop                        distance
//   config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// While full is low a pair is taken every cycle; its term is pipelined into the running sum.
// Manhattan and norm-based results are on the result ports in the cycle after their sum
// leaves the job queue; a Euclidean sum starts the root unit, which resolves one result bit
// per cycle, and its result is loaded once the root is done and the output register is free.
// Reset clears the running sum, the queue pointers and the metric selector; no clearing pass.
// full rises when queued sums plus last items still in the front pipeline fill the queue.
module vector_distance_engine_top #(
	parameter int ELEM_WIDTH = vde_pkg::ELEM_WIDTH_DEF,
	parameter int JOB_DEPTH  = vde_pkg::JQ_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [vde_pkg::PADDR_W-1:0]       paddr,
	input  logic [vde_pkg::PDATA_W-1:0]       pwdata,
	output logic [vde_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	// Element pairs.
	input  logic                              push,
	output logic                              full,
	input  logic signed [ELEM_WIDTH-1:0]      elem_a,
	input  logic signed [ELEM_WIDTH-1:0]      elem_b,
	input  logic [vde_pkg::NORM_W-1:0]        norm_a,
	input  logic [vde_pkg::NORM_W-1:0]        norm_b,
	input  logic                              last_element,
	// Distances.
	output logic                              empty,
	input  logic                              pop,
	output logic signed [vde_pkg::DIST_W-1:0] distance
);
	import vde_pkg::*;

	localparam int CNT_W    = $clog2(JOB_DEPTH + 1);
	localparam int CREDIT_W = CNT_W + 2;

	logic [MODE_W-1:0] metric_mode_q;
	logic              cfg_write, reg_hit;

	logic              in_transfer, out_transfer;
	logic              job_push, job_pop, out_valid;
	vde_job_t          job_in, job_out;
	logic [CNT_W-1:0]  jq_count;
	logic [1:0]        lasts_inflight;
	logic [CREDIT_W-1:0] credit_used;

	// The register sits at byte address zero; the two low address bits are ignored.
	assign reg_hit   = paddr[PADDR_W-1:2] == REG_METRIC_MODE;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_mode_q <= MODE_MANHATTAN;
		end else if (cfg_write && reg_hit) begin
			metric_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign prdata = (psel && reg_hit) ? PDATA_W'(metric_mode_q) : '0;

	// A transfer is only offered while every last item already accepted is sure of a
	// slot in the job queue, so the front pipeline never has to stall.
	assign credit_used  = CREDIT_W'(jq_count) + CREDIT_W'(lasts_inflight);
	assign full         = credit_used >= CREDIT_W'(JOB_DEPTH);
	assign in_transfer  = push && !full;
	assign empty        = !out_valid;
	assign out_transfer = pop && !empty;

	vde_front #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_transfer),
		.elem_a         (elem_a),
		.elem_b         (elem_b),
		.norm_a         (norm_a),
		.norm_b         (norm_b),
		.last_element   (last_element),
		.mode           (metric_mode_q),
		.job_push       (job_push),
		.job            (job_in),
		.lasts_inflight (lasts_inflight)
	);

	vde_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_out),
		.count  (jq_count)
	);

	// The back end drains one sum at a time and keeps its result until the consumer
	// takes it with a transfer on the result side.
	vde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (jq_count != '0),
		.job       (job_out),
		.job_pop   (job_pop),
		.out_pop   (out_transfer),
		.out_valid (out_valid),
		.distance  (distance)
	);

	// The credit scheme must keep the job queue from ever overflowing.
	assert property (@(posedge clk) disable iff (!arst_n)
		credit_used <= CREDIT_W'(JOB_DEPTH))
		else $error("job queue credit exceeded");

	assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (jq_count < CNT_W'(JOB_DEPTH)) || job_pop)
		else $error("push into a full job queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> jq_count != '0)
		else $error("pop from an empty job queue");

	// A result can only appear in the cycle after a sum left the queue or the root unit ran.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(jq_count) != '0 || !$past(job_pop))
		else $error("result without a job");

endmodule

// ===== hw/rtl/vde_front.sv =====
// Front end: three-stage pipeline that forms each element term and accumulates it.
// Depends on vde_pkg; emits one job per vector on the item that carries the last mark.
module vde_front #(
	parameter int ELEM_WIDTH = vde_pkg::ELEM_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [ELEM_WIDTH-1:0]   elem_a,
	input  logic signed [ELEM_WIDTH-1:0]   elem_b,
	input  logic [vde_pkg::NORM_W-1:0]     norm_a,
	input  logic [vde_pkg::NORM_W-1:0]     norm_b,
	input  logic                           last_element,
	input  logic [vde_pkg::MODE_W-1:0]     mode,
	output logic                           job_push,
	output vde_pkg::vde_job_t              job,
	output logic [1:0]                     lasts_inflight
);
	import vde_pkg::*;

	localparam int DIFF_W = ELEM_WIDTH + 1;
	localparam int OP_W   = ELEM_WIDTH + 2;
	localparam int PROD_W = 2 * OP_W;
	localparam int TERM_W = (PROD_W > DIST_W + 1) ? PROD_W : DIST_W + 1;
	localparam int ACC_W  = TERM_W + 1;
	localparam int CMP_W  = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;

	// Stage 1: captured item.
	logic                         valid_s1, last_s1;
	logic [MODE_W-1:0]            mode_s1;
	logic signed [ELEM_WIDTH-1:0] a_s1, b_s1;
	logic [NORM_W-1:0]            norm_a_s1, norm_b_s1;

	// Stage 2: multiplier operands.
	logic                         valid_s2, last_s2, big_s2;
	logic [MODE_W-1:0]            mode_s2;
	logic signed [OP_W-1:0]       op_x_s2, op_y_s2;
	logic [DIFF_W-1:0]            abs_s2;
	logic [NORM_W-1:0]            norm_a_s2, norm_b_s2;

	// Stage 3: term ready to accumulate.
	logic                         valid_s3, last_s3;
	logic [MODE_W-1:0]            mode_s3;
	logic signed [TERM_W-1:0]     term_s3;
	logic [NORM_W-1:0]            norm_a_s3, norm_b_s3;

	logic signed [DIST_W-1:0]     running_q;

	logic signed [DIFF_W-1:0]     diff;
	logic [DIFF_W-1:0]            abs_diff;
	logic                         big;
	logic signed [OP_W-1:0]       op_x, op_y;
	logic signed [PROD_W-1:0]     prod;
	logic signed [TERM_W-1:0]     term;
	logic signed [ACC_W-1:0]      acc;
	logic signed [DIST_W-1:0]     acc_sat;

	always_comb begin
		diff     = DIFF_W'(a_s1) - DIFF_W'(b_s1);
		abs_diff = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
		big      = CMP_W'(abs_diff) > CMP_W'(DIFF_SQ_LIMIT);
		if (mode_s1 == MODE_EUCLID) begin
			op_x = $signed({1'b0, abs_diff});
			op_y = $signed({1'b0, abs_diff});
		end else begin
			op_x = OP_W'(a_s1);
			op_y = OP_W'(b_s1);
		end
	end

	always_comb begin
		prod = op_x_s2 * op_y_s2;
		priority if (mode_s2 == MODE_EUCLID) begin
			term = big_s2 ? TERM_W'(SUM_MAX) : TERM_W'(prod);
		end else if (mode_s2 == MODE_NORM) begin
			term = TERM_W'(prod);
		end else begin
			term = $signed(TERM_W'(abs_s2));
		end
	end

	always_comb begin
		acc = ACC_W'(running_q) + ACC_W'(term_s3);
		priority if (acc > ACC_W'(SUM_MAX)) begin
			acc_sat = SUM_MAX;
		end else if (acc < ACC_W'(SUM_MIN)) begin
			acc_sat = SUM_MIN;
		end else begin
			acc_sat = acc[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			last_s1   <= 1'b0;
			last_s2   <= 1'b0;
			last_s3   <= 1'b0;
			running_q <= '0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			last_s1  <= in_valid & last_element;
			last_s2  <= valid_s1 & last_s1;
			last_s3  <= valid_s2 & last_s2;
			if (valid_s3) begin
				running_q <= last_s3 ? '0 : acc_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s1      <= elem_a;
		b_s1      <= elem_b;
		mode_s1   <= mode;
		norm_a_s1 <= norm_a;
		norm_b_s1 <= norm_b;

		op_x_s2   <= op_x;
		op_y_s2   <= op_y;
		abs_s2    <= abs_diff;
		big_s2    <= big;
		mode_s2   <= mode_s1;
		norm_a_s2 <= norm_a_s1;
		norm_b_s2 <= norm_b_s1;

		term_s3   <= term;
		mode_s3   <= mode_s2;
		norm_a_s3 <= norm_a_s2;
		norm_b_s3 <= norm_b_s2;
	end

	assign job_push = valid_s3 & last_s3;
	assign job      = '{mode: mode_s3, sum: acc_sat, norm_a: norm_a_s3, norm_b: norm_b_s3};

	assign lasts_inflight = 2'(valid_s1 & last_s1) + 2'(valid_s2 & last_s2)
		+ 2'(valid_s3 & last_s3);

endmodule

// ===== hw/rtl/vde_jobq.sv =====
// Short register queue that holds finished vector sums between front and back.
// Depends on vde_pkg for the job type.
module vde_jobq #(
	parameter int DEPTH = vde_pkg::JQ_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  vde_pkg::vde_job_t                din,
	input  logic                             pop,
	output vde_pkg::vde_job_t                dout,
	output logic [$clog2(DEPTH+1)-1:0]       count
);
	import vde_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vde_job_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== hw/rtl/vde_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on vde_pkg for widths and the starting bit.
module vde_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [vde_pkg::DIST_W-1:0]     radicand,
	output logic                           busy,
	output logic [vde_pkg::ROOT_W-1:0]     root
);
	import vde_pkg::*;

	logic [DIST_W-1:0] x_q, res_q, bit_q;
	logic [DIST_W:0]   trial;
	logic              take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, x_q} >= trial;
	assign busy  = |bit_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= ROOT_TOP_BIT;
		end else if (busy) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
		end else if (busy) begin
			if (take) begin
				x_q   <= x_q - trial[DIST_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// ===== hw/rtl/vde_back.sv =====
// Back end: turns a finished vector sum into a distance and holds it for the consumer.
// Depends on vde_pkg and vde_isqrt.
module vde_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  vde_pkg::vde_job_t               job,
	output logic                            job_pop,
	input  logic                            out_pop,
	output logic                            out_valid,
	output logic signed [vde_pkg::DIST_W-1:0] distance
);
	import vde_pkg::*;

	localparam int NR_W = DIST_W + 2;

	vde_back_st_t             state_q, state_nx;
	logic                     out_valid_q;
	logic signed [DIST_W-1:0] dist_q;

	logic                     out_free, sq_start, sq_busy, load_out;
	logic [DIST_W-1:0]        radicand;
	logic [ROOT_W-1:0]        root;
	logic signed [NR_W-1:0]   norm_res;
	logic signed [DIST_W-1:0] norm_sat, out_val;

	assign out_free = !out_valid_q || out_pop;
	assign radicand = job.sum[DIST_W-1] ? '0 : $unsigned(job.sum);

	vde_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.busy     (sq_busy),
		.root     (root)
	);

	always_comb begin
		norm_res = $signed(NR_W'(job.norm_a)) + $signed(NR_W'(job.norm_b))
			- (NR_W'(job.sum) <<< 1);
		priority if (norm_res > NR_W'(SUM_MAX)) begin
			norm_sat = SUM_MAX;
		end else if (norm_res < NR_W'(SUM_MIN)) begin
			norm_sat = SUM_MIN;
		end else begin
			norm_sat = norm_res[DIST_W-1:0];
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid && out_free && job.mode == MODE_EUCLID) begin
					state_nx = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (!sq_busy && out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		sq_start = 1'b0;
		load_out = 1'b0;
		out_val  = job.sum;
		unique case (state_q)
			ST_IDLE: begin
				job_pop  = job_valid && out_free;
				sq_start = job_pop && job.mode == MODE_EUCLID;
				load_out = job_pop && job.mode != MODE_EUCLID;
				out_val  = (job.mode == MODE_NORM) ? norm_sat : job.sum;
			end
			ST_ROOT: begin
				load_out = !sq_busy && out_free;
				out_val  = $signed(DIST_W'(root));
			end
			default: begin
				job_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dist_q <= out_val;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;

endmodule
